@@ design/bxid_pkg.sv @@
package bxid_pkg;

  localparam int MAX_BLOCK = 8192;
  localparam int LENGTH_BITS = 24;
  localparam int BYTE_W = 8;
  localparam int BLK_REG_W = 14;
  localparam int BLK_W = $clog2(MAX_BLOCK + 1);
  localparam int WIDE_W = ((LENGTH_BITS > BLK_W) ? LENGTH_BITS : BLK_W) + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = (LENGTH_BITS > BLK_REG_W) ? LENGTH_BITS : BLK_REG_W;
  localparam int DIV_CNT_W = $clog2(LENGTH_BITS);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_KEY     = 3'd0,
    REG_KEY_STEP      = 3'd1,
    REG_BLOCK_LENGTH  = 3'd2,
    REG_DECRYPT_LIMIT = 3'd3,
    REG_STREAM_LENGTH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      data;
    logic [BYTE_W-1:0]      key;
    logic [LENGTH_BITS-1:0] pos;
    logic                   dec;
    logic                   last;
  } item_t;

endpackage

@@ design/bxid_mod.sv @@
module bxid_mod (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bxid_pkg::LENGTH_BITS-1:0] dividend,
  input  logic [bxid_pkg::BLK_W-1:0]       divisor,
  output logic                             done,
  output logic [bxid_pkg::BLK_W-1:0]       rem
);
  import bxid_pkg::*;

  logic                   busy;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [LENGTH_BITS-1:0] dvd;
  logic [BLK_W-1:0]       dvs;
  logic [BLK_W-1:0]       part;
  logic [BLK_W:0]         trial;
  logic [BLK_W-1:0]       part_next;
  logic                   cnt_last;

  // One quotient bit per cycle, restoring form; only the remainder is kept.
  always_comb begin
    trial = {part, dvd[LENGTH_BITS-1]};
    if (trial >= {1'b0, dvs}) begin
      part_next = BLK_W'(trial - {1'b0, dvs});
    end else begin
      part_next = trial[BLK_W-1:0];
    end
    cnt_last = (cnt == DIV_CNT_W'(LENGTH_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      dvd  <= dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (busy) begin
      part <= part_next;
      dvd  <= {dvd[LENGTH_BITS-2:0], 1'b0};
      cnt  <= cnt + DIV_CNT_W'(1);
      done <= cnt_last;
      busy <= !cnt_last;
    end else begin
      done <= 1'b0;
    end
  end

  assign rem = part;

endmodule

@@ design/bxid_front.sv @@
module bxid_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bxid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bxid_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic [bxid_pkg::BYTE_W-1:0]     in_byte,
  input  logic                            q_full,
  output logic                            q_wr,
  output bxid_pkg::item_t                 q_item
);
  import bxid_pkg::*;

  typedef enum logic [2:0] {
    ST_START = 3'b001,
    ST_DIV   = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

  state_t state, state_next;

  logic [BYTE_W-1:0]      cfg_start_key;
  logic [BYTE_W-1:0]      cfg_key_step;
  logic [BLK_REG_W-1:0]   cfg_block_len;
  logic [LENGTH_BITS-1:0] cfg_limit;
  logic [LENGTH_BITS-1:0] cfg_len;

  logic [LENGTH_BITS-1:0] lat_len;
  logic [LENGTH_BITS-1:0] lat_limit;
  logic [BLK_W-1:0]       lat_block;
  logic [BYTE_W-1:0]      lat_step;
  logic [BYTE_W-1:0]      running_key;

  logic [LENGTH_BITS-1:0] byte_index;
  logic [LENGTH_BITS-1:0] enc_len;
  logic [LENGTH_BITS-1:0] block_start;
  logic [LENGTH_BITS-1:0] rem_len;
  logic [BLK_W-1:0]       index_in_block;
  logic [BLK_W-1:0]       cur_size;
  logic [BLK_W-1:0]       cur_half;
  logic [LENGTH_BITS-1:0] base_pos;
  logic [LENGTH_BITS-1:0] pos_reg;
  logic                   block_on;

  logic [BLK_W-1:0]       blk_clamped;
  logic                   mod_done;
  logic [BLK_W-1:0]       mod_rem;
  logic [BLK_W-1:0]       r_kept;
  logic [WIDE_W-1:0]      tail;
  logic [LENGTH_BITS-1:0] enc_len_calc;

  logic                   accept;
  logic                   is_last;
  logic                   in_enc;
  logic                   first;
  logic [WIDE_W-1:0]      rem_wide;
  logic [WIDE_W-1:0]      blk_wide;
  logic [BLK_W-1:0]       s;
  logic [BLK_W-1:0]       half;
  logic [LENGTH_BITS-1:0] base;
  logic                   on;
  logic [LENGTH_BITS-1:0] pos_cur;
  logic [BLK_W-1:0]       k_next;
  logic                   blk_end;
  logic [LENGTH_BITS-1:0] pos_next;
  logic                   dec;

  always_comb begin
    if (cfg_block_len == '0) begin
      blk_clamped = BLK_W'(1);
    end else if (32'(cfg_block_len) > 32'(MAX_BLOCK)) begin
      blk_clamped = BLK_W'(MAX_BLOCK);
    end else begin
      blk_clamped = BLK_W'(cfg_block_len);
    end
  end

  bxid_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (cfg_len),
    .divisor  (blk_clamped),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // The tail is the short remainder plus one byte for an odd length.
  always_comb begin
    r_kept = (mod_rem >= (lat_block >> 2)) ? '0 : mod_rem;
    tail   = WIDE_W'(r_kept) + WIDE_W'(lat_len[0]);
    if (WIDE_W'(lat_len) > tail) begin
      enc_len_calc = LENGTH_BITS'(WIDE_W'(lat_len) - tail);
    end else begin
      enc_len_calc = '0;
    end
  end

  assign cfg_ready = 1'b1;
  assign full      = (state != ST_RUN) || q_full || (cfg_valid && (byte_index == '0));
  assign accept    = push && !full;

  always_comb begin
    is_last  = ((WIDE_W'(byte_index) + WIDE_W'(1)) >= WIDE_W'(lat_len));
    in_enc   = (byte_index < enc_len);
    first    = (index_in_block == '0);
    rem_wide = WIDE_W'(rem_len);
    blk_wide = WIDE_W'(lat_block);
    if (first) begin
      s    = (rem_wide < blk_wide) ? BLK_W'(rem_len) : lat_block;
      half = BLK_W'(({1'b0, s} + (BLK_W + 1)'(1)) >> 1);
      base = LENGTH_BITS'(WIDE_W'(block_start) + WIDE_W'(s) - WIDE_W'(1));
      on   = (block_start < lat_limit);
      pos_cur = base;
    end else begin
      s       = cur_size;
      half    = cur_half;
      base    = base_pos;
      on      = block_on;
      pos_cur = pos_reg;
    end
    k_next   = index_in_block + BLK_W'(1);
    blk_end  = (k_next >= s);
    pos_next = (k_next == half) ? (base - LENGTH_BITS'(1)) : (pos_cur - LENGTH_BITS'(2));
    dec      = in_enc && on;
  end

  always_comb begin
    q_wr        = accept;
    q_item.data = in_byte;
    q_item.key  = running_key;
    q_item.pos  = dec ? pos_cur : byte_index;
    q_item.dec  = dec;
    q_item.last = is_last;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (mod_done) state_next = ST_RUN;
      ST_RUN:   if (accept && is_last) state_next = ST_START;
      default:  state_next = ST_START;
    endcase
    if (cfg_valid && (byte_index == '0)) begin
      state_next = ST_START;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_START;
      byte_index    <= '0;
      cfg_start_key <= '0;
      cfg_key_step  <= '0;
      cfg_block_len <= BLK_REG_W'(64);
      cfg_limit     <= LENGTH_BITS'(10240);
      cfg_len       <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_START_KEY:     cfg_start_key <= cfg_data[BYTE_W-1:0];
          REG_KEY_STEP:      cfg_key_step  <= cfg_data[BYTE_W-1:0];
          REG_BLOCK_LENGTH:  cfg_block_len <= cfg_data[BLK_REG_W-1:0];
          REG_DECRYPT_LIMIT: cfg_limit     <= cfg_data[LENGTH_BITS-1:0];
          REG_STREAM_LENGTH: cfg_len       <= cfg_data[LENGTH_BITS-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_START: begin
          lat_len        <= cfg_len;
          lat_block      <= blk_clamped;
          lat_limit      <= cfg_limit;
          lat_step       <= cfg_key_step;
          running_key    <= cfg_start_key;
          block_start    <= '0;
          index_in_block <= '0;
        end
        ST_DIV: begin
          if (mod_done) begin
            enc_len <= enc_len_calc;
            rem_len <= enc_len_calc;
          end
        end
        ST_RUN: begin
          if (accept) begin
            byte_index <= is_last ? '0 : (byte_index + LENGTH_BITS'(1));
            if (dec) begin
              running_key <= running_key + lat_step;
            end
            if (in_enc) begin
              cur_size <= s;
              cur_half <= half;
              base_pos <= base;
              block_on <= on;
              pos_reg  <= pos_next;
              if (blk_end) begin
                index_in_block <= '0;
                block_start    <= LENGTH_BITS'(WIDE_W'(block_start) + WIDE_W'(s));
                rem_len        <= LENGTH_BITS'(WIDE_W'(rem_len) - WIDE_W'(s));
              end else begin
                index_in_block <= k_next;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ design/bxid_fifo.sv @@
module bxid_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  bxid_pkg::item_t wr_item,
  output logic            q_full,
  input  logic            rd,
  output logic            avail,
  output bxid_pkg::item_t head
);
  import bxid_pkg::*;

  item_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_wr;
  logic                  do_rd;

  assign q_full = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign avail  = (count != '0);
  assign head   = mem[rd_ptr];
  assign do_wr  = wr && !q_full;
  assign do_rd  = rd && avail;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : (wr_ptr + FIFO_PTR_W'(1));
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : (rd_ptr + FIFO_PTR_W'(1));
      end
      if (do_wr && !do_rd) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

@@ design/bxid_back.sv @@
module bxid_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             avail,
  input  bxid_pkg::item_t                  head,
  output logic                             take,
  output logic                             empty,
  input  logic                             pop,
  output logic [bxid_pkg::BYTE_W-1:0]      out_byte,
  output logic [bxid_pkg::LENGTH_BITS-1:0] out_position,
  output logic                             was_decrypted,
  output logic                             last
);
  import bxid_pkg::*;

  logic out_valid;

  assign empty = !out_valid;
  assign take  = avail && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte      <= head.dec ? (head.data ^ head.key) : head.data;
      out_position  <= head.pos;
      was_decrypted <= head.dec;
      last          <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/blockwise_xor_interleave_decrypt.sv @@
// Stream decryptor that returns every byte with the offset where it belongs.
// Input queue side: a request is taken when push is high and full is low.
// Result queue side: the oldest result is on the ports while empty is low and
// leaves when pop is high. Each request yields exactly one result, in order.
// Registers are written through cfg_valid, cfg_ready, cfg_index and cfg_data;
// cfg_ready is always high. Settings take effect at the start of a stream.
// Before the first byte of every stream, and after each register write while
// no stream is open, full stays high while the remainder unit divides the
// stream length by the block length, one bit per cycle. Within a stream one
// request is taken every cycle while the queue ahead has room. A taken
// request is written into the queue, then registered by the output stage,
// where it shows up on the result side. When pop stays low, results pile up
// in the two-entry queue between the classifying front and the output stage,
// then full rises until pop returns. After reset, full stays high for the
// first remainder computation and empty is high; registers take reset values.
module blockwise_xor_interleave_decrypt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bxid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bxid_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [bxid_pkg::BYTE_W-1:0]      in_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [bxid_pkg::BYTE_W-1:0]      out_byte,
  output logic [bxid_pkg::LENGTH_BITS-1:0] out_position,
  output logic                             was_decrypted,
  output logic                             last
);
  import bxid_pkg::*;

  logic  q_wr;
  item_t q_item;
  logic  q_full;
  logic  q_avail;
  logic  q_take;
  item_t q_head;

  bxid_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (q_item)
  );

  bxid_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (q_item),
    .q_full  (q_full),
    .rd      (q_take),
    .avail   (q_avail),
    .head    (q_head)
  );

  bxid_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (q_avail),
    .head          (q_head),
    .take          (q_take),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_position  (out_position),
    .was_decrypted (was_decrypted),
    .last          (last)
  );

endmodule

@@ design/bxid_check.sv @@
module bxid_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [bxid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [bxid_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                             push,
  input logic                             full,
  input logic [bxid_pkg::BYTE_W-1:0]      in_byte,
  input logic                             empty,
  input logic                             pop,
  input logic [bxid_pkg::BYTE_W-1:0]      out_byte,
  input logic [bxid_pkg::LENGTH_BITS-1:0] out_position,
  input logic                             was_decrypted,
  input logic                             last
);

  a_reset_state: assert property (@(posedge clk) rst |=> (empty && full))
    else $error("block not closed and empty after reset");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write was stalled");

  a_request_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (push && !full && empty) |-> ##2 !empty)
    else $error("request did not reach an idle output in two cycles");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_position)
                          && $stable(was_decrypted) && $stable(last)))
    else $error("waiting result changed before it was taken");

endmodule

bind blockwise_xor_interleave_decrypt bxid_check u_check (.*);
